// ===== design/puc_pkg.sv =====
// Shared types and constants for the destination-over compositing pipeline.
`default_nettype none

package puc_pkg;

    localparam int NUM_CHAN       = 3;
    localparam int CHAN_W         = 8;
    localparam int PX_W           = 4 * CHAN_W;
    localparam int NUM_W          = 2 * CHAN_W;
    localparam int N_DIV_STAGES   = 4;
    localparam int BITS_PER_STAGE = CHAN_W / N_DIV_STAGES;

    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO  = 8'h00;
    localparam logic [NUM_W-1:0]  ROUND_BIAS = 16'd128;

    // Stage 1: unpacked alphas and the alpha and per-channel products per pixel
    typedef struct packed {
        logic                             pass;
        logic [PX_W-1:0]                  pass_px;
        logic                             high;
        logic [CHAN_W-1:0]                sa;
        logic [CHAN_W-1:0]                da;
        logic [NUM_W-1:0]                 prod;
        logic [NUM_CHAN-1:0][NUM_W-1:0]   cd;
        logic [NUM_CHAN-1:0][NUM_W-1:0]   cs;
    } t_s1;

    // Division stages: divisor, partial remainders and quotient bits
    typedef struct packed {
        logic                             pass;
        logic [PX_W-1:0]                  pass_px;
        logic                             high;
        logic [CHAN_W-1:0]                ra;
        logic [NUM_CHAN-1:0][NUM_W-1:0]   rem;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]  q;
        logic [NUM_CHAN-1:0]              sat;
    } t_div;

endpackage

`default_nettype wire

// ===== design/puc_div2.sv =====
// One pipeline stage of the restoring divider: two quotient bits per channel.
`default_nettype none

module puc_div2
    import puc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_step,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_div       i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_div            o_data
);

    logic r_valid;
    t_div r_data;
    t_div n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // two dependent trial subtractions per channel
    always_comb begin
        logic [2:0]       b;
        logic [NUM_W-1:0] cmp;
        n_data = i_data;
        for (int c = 0; c < NUM_CHAN; c++) begin
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                b   = 3'(CHAN_W - 1 - BITS_PER_STAGE * int'(i_step) - j);
                cmp = {{(NUM_W-CHAN_W){1'b0}}, i_data.ra} << b;
                if (n_data.rem[c] >= cmp) begin
                    n_data.rem[c]  = n_data.rem[c] - cmp;
                    n_data.q[c][b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/premul_under_straight_composite.sv =====
// Top level: composites a premultiplied shadow pixel behind a straight-alpha pixel.
//
// Usage:
//  - Slave stream carries one word per pixel pair: destination pixel in the
//    low 32 bits, shadow pixel in the high 32 bits. Master stream returns one
//    composited straight-alpha pixel per accepted word, in order.
//  - Configuration channel writes the single mode bit (alpha in the high byte
//    when set). Write it only while the pipeline is empty; it is always ready.
//  - Throughput: one pixel per clock, sustained while the master side is ready.
//  - Pipeline from acceptance to the result on the master side:
//    one stage of 8x8 multipliers, one stage forming the result alpha and the
//    channel numerators, four stages of a restoring divider (two quotient
//    bits per stage), shared divisor across the three colour channels.
//  - Reset (synchronous, active low) empties every stage and clears the mode
//    bit to alpha-in-low-byte.
//  - When the receiver stalls, each stage holds its word; the input keeps
//    being accepted until every stage is full, so bubbles are squeezed out.
`default_nettype none

module premul_under_straight_composite
    import puc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_data,       // alpha_in_high_byte
    // slave stream
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [2*PX_W-1:0] i_s_axis_tdata,   // [31:0] dest_pixel, [63:32] shadow_pixel
    // master stream
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [PX_W-1:0]        o_m_axis_tdata    // [31:0] result_pixel
);

    logic r_alpha_hi;

    logic r_v1;
    t_s1  r_s1;
    t_s1  n_s1;
    logic rdy1;

    logic r_v2;
    t_div r_s2;
    t_div n_s2;
    logic rdy2;

    logic [N_DIV_STAGES:0] dv_valid;
    logic [N_DIV_STAGES:0] dv_ready;
    t_div                  dv_data [N_DIV_STAGES+1];

    // mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_hi <= 1'b0;
        end else if (i_cfg_valid) begin
            r_alpha_hi <= i_cfg_data;
        end
    end

    // ready chain back from the output
    assign rdy2            = !r_v2 || dv_ready[0];
    assign rdy1            = !r_v1 || rdy2;
    assign o_s_axis_tready = rdy1;

    // stage 1: unpack, bypass decision, products
    always_comb begin
        logic [PX_W-1:0]   dpx;
        logic [PX_W-1:0]   spx;
        logic [4:0]        apos;
        logic [4:0]        pos;
        logic [CHAN_W-1:0] dc;
        logic [CHAN_W-1:0] sc;
        dpx       = i_s_axis_tdata[PX_W-1:0];
        spx       = i_s_axis_tdata[2*PX_W-1:PX_W];
        apos      = r_alpha_hi ? 5'd24 : 5'd0;
        n_s1.high = r_alpha_hi;
        n_s1.da   = dpx[apos +: CHAN_W];
        n_s1.sa   = spx[apos +: CHAN_W];
        n_s1.pass = (n_s1.da == CHAN_MAX) || (n_s1.sa == CHAN_ZERO)
                    || (n_s1.da == CHAN_ZERO);
        n_s1.pass_px = ((n_s1.da == CHAN_MAX) || (n_s1.sa == CHAN_ZERO)) ? dpx : spx;
        n_s1.prod = NUM_W'(n_s1.sa * n_s1.da);
        for (int k = 0; k < NUM_CHAN; k++) begin
            pos        = (r_alpha_hi ? 5'd0 : 5'd8) + 5'(CHAN_W * k);
            dc         = dpx[pos +: CHAN_W];
            sc         = spx[pos +: CHAN_W];
            n_s1.cd[k] = NUM_W'(dc * n_s1.da);
            n_s1.cs[k] = NUM_W'(sc * (CHAN_MAX - n_s1.da));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: result alpha, numerators, saturation check
    always_comb begin
        logic [NUM_W-1:0]  t;
        logic [NUM_W-1:0]  t2;
        logic [CHAN_W:0]   asum;
        logic [CHAN_W-1:0] ra;
        logic [NUM_W-1:0]  num;
        t    = r_s1.prod + ROUND_BIAS;
        t2   = t + (t >> CHAN_W);
        asum = {1'b0, r_s1.sa} + {1'b0, r_s1.da} - {1'b0, t2[NUM_W-1:CHAN_W]};
        ra   = asum[CHAN_W-1:0];
        if (ra == CHAN_ZERO) begin
            ra = 8'd1;
        end
        n_s2.pass    = r_s1.pass;
        n_s2.pass_px = r_s1.pass_px;
        n_s2.high    = r_s1.high;
        n_s2.ra      = ra;
        for (int k = 0; k < NUM_CHAN; k++) begin
            num = r_s1.cd[k] + r_s1.cs[k] + {{(NUM_W-CHAN_W+1){1'b0}}, ra[CHAN_W-1:1]};
            n_s2.rem[k] = num;
            n_s2.q[k]   = CHAN_ZERO;
            n_s2.sat[k] = num >= {ra, CHAN_ZERO};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

    // stages 3 to 6: divider
    assign dv_valid[0]              = r_v2;
    assign dv_data[0]               = r_s2;
    assign dv_ready[N_DIV_STAGES]   = i_m_axis_tready;

    for (genvar g = 0; g < N_DIV_STAGES; g++) begin : g_div
        puc_div2 u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (2'(g)),
            .i_valid (dv_valid[g]),
            .o_ready (dv_ready[g]),
            .i_data  (dv_data[g]),
            .o_valid (dv_valid[g+1]),
            .i_ready (dv_ready[g+1]),
            .o_data  (dv_data[g+1])
        );
    end

    // pack the result word
    always_comb begin
        t_div       d;
        logic [4:0] pos;
        d              = dv_data[N_DIV_STAGES];
        o_m_axis_tdata = '0;
        o_m_axis_tdata[(d.high ? 5'd24 : 5'd0) +: CHAN_W] = d.ra;
        for (int k = 0; k < NUM_CHAN; k++) begin
            pos = (d.high ? 5'd0 : 5'd8) + 5'(CHAN_W * k);
            o_m_axis_tdata[pos +: CHAN_W] = d.sat[k] ? CHAN_MAX : d.q[k];
        end
        if (d.pass) begin
            o_m_axis_tdata = d.pass_px;
        end
    end

    assign o_m_axis_tvalid = dv_valid[N_DIV_STAGES];

    // checks
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with an empty output stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && (&dv_valid[N_DIV_STAGES:1])))
        else $error("input stalled while a stage holds a bubble");

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chk
        a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_m_axis_tvalid && !dv_data[N_DIV_STAGES].pass && !dv_data[N_DIV_STAGES].sat[c])
            |-> (dv_data[N_DIV_STAGES].rem[c] < {8'd0, dv_data[N_DIV_STAGES].ra}))
            else $error("divider remainder not below divisor");
    end

endmodule

`default_nettype wire
